>>> rtl/nfu_pkg.sv
package nfu_pkg;

  // Fixed field widths
  localparam int PageW    = 8;
  localparam int FrameIdW = 2;
  localparam int CfgW     = 3;

  // frames_in_use after reset
  localparam logic [CfgW-1:0] FramesReset = 3'd4;

  // Result codes
  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_PLACED  = 2'd1,
    OUT_REPLACE = 2'd2
  } outcome_e;

  // One result transaction
  typedef struct packed {
    outcome_e                outcome;
    logic [FrameIdW-1:0]     frame_index;
    logic [PageW-1:0]        evicted_page;
  } res_t;

endpackage

>>> rtl/nfu_cnt.sv
// Front end: accepts a reference and does the read-modify-write of its use count.
module nfu_cnt #(
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [nfu_pkg::PageW-1:0]   page_name_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output logic [nfu_pkg::PageW-1:0]   q_page_o,
  output logic [COUNT_BITS-1:0]       q_count_o
);

  localparam int Entries = 1 << nfu_pkg::PageW;

  logic                        busy_q, busy_d;
  logic                        accept;
  logic [nfu_pkg::PageW-1:0]   page_q;
  logic [COUNT_BITS-1:0]       rd_data_q;
  logic                        rd_vld_q;
  logic [Entries-1:0]          cnt_vld_q;
  logic [COUNT_BITS-1:0]       cnt_mem_q [Entries];
  logic [COUNT_BITS-1:0]       cur_cnt;
  logic [COUNT_BITS-1:0]       new_cnt;

  // One reference in flight; the queue has room for it whenever we accept
  assign full   = busy_q | q_full_i;
  assign accept = push & ~full;
  assign busy_d = accept;

  // Never-written counts read as zero; saturate at all ones
  assign cur_cnt   = rd_vld_q ? rd_data_q : '0;
  assign new_cnt   = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
  assign q_push_o  = busy_q;
  assign q_page_o  = page_q;
  assign q_count_o = new_cnt;

  // Control and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_vld_q <= '0;
    end else begin
      busy_q <= busy_d;
      if (busy_q) begin
        cnt_vld_q[page_q] <= 1'b1;
      end
    end
  end

  // Count memory: registered read on accept, write back in the following cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q    <= page_name_i;
      rd_data_q <= cnt_mem_q[page_name_i];
      rd_vld_q  <= cnt_vld_q[page_name_i];
    end
    if (busy_q) begin
      cnt_mem_q[page_q] <= new_cnt;
    end
  end

endmodule

>>> rtl/nfu_fifo.sv
// Small queue between the count stage and the frame stage.
module nfu_fifo #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             vld_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign vld_o   = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & vld_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/nfu_frames.sv
// Back end: frame search, min-count victim choice and frame table update.
module nfu_frames #(
  parameter int FRAMES     = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [nfu_pkg::CfgW-1:0]    frames_in_use_i,
  input  logic                        item_vld_i,
  input  logic [nfu_pkg::PageW-1:0]   item_page_i,
  input  logic [COUNT_BITS-1:0]       item_cnt_i,
  output logic                        item_rdy_o,
  output logic                        res_vld_o,
  output nfu_pkg::res_t               res_o,
  input  logic                        res_pop_i
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int P  = 1 << $clog2(FRAMES);
  localparam int NN = 2 * P - 1;

  logic [nfu_pkg::PageW-1:0] pg_q  [FRAMES];
  logic [COUNT_BITS-1:0]     cnt_q [FRAMES];
  logic [FRAMES-1:0]         vld_q;

  logic [FRAMES-1:0]         active;
  logic [FRAMES-1:0]         cand;
  logic [FRAMES-1:0]         match;
  logic                      found;
  logic [IW-1:0]             sel;
  logic                      sel_empty;
  logic [IW-1:0]             victim;
  logic                      fire;

  logic [COUNT_BITS-1:0]     node_cnt [NN];
  logic [IW-1:0]             node_idx [NN];
  logic                      node_ok  [NN];

  logic                      res_vld_q, res_vld_d;
  nfu_pkg::res_t             res_q, res_d;
  logic [IW+1:0]             idx_ext;

  // Active frames: frame 0 always, others below the configured count
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      active[i] = (i == 0) || (i < int'(frames_in_use_i));
      match[i]  = vld_q[i] && (pg_q[i] == item_page_i);
      cand[i]   = active[i] && (!vld_q[i] || (pg_q[i] == item_page_i));
    end
  end

  // First empty or matching active frame
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (!found && cand[i]) begin
        found = 1'b1;
        sel   = IW'(i);
      end
    end
  end
  assign sel_empty = ~vld_q[sel];

  // Min-count tree over active frames, lower frame wins ties
  always_comb begin
    for (int k = 0; k < NN; k++) begin
      node_cnt[k] = '0;
      node_idx[k] = '0;
      node_ok[k]  = 1'b0;
    end
    for (int i = 0; i < P; i++) begin
      if (i < FRAMES) begin
        node_cnt[P-1+i] = cnt_q[i];
        node_idx[P-1+i] = IW'(i);
        node_ok[P-1+i]  = active[i];
      end
    end
    for (int k = P - 2; k >= 0; k--) begin
      if (node_ok[2*k+1] && (!node_ok[2*k+2] || node_cnt[2*k+1] <= node_cnt[2*k+2])) begin
        node_cnt[k] = node_cnt[2*k+1];
        node_idx[k] = node_idx[2*k+1];
        node_ok[k]  = node_ok[2*k+1];
      end else begin
        node_cnt[k] = node_cnt[2*k+2];
        node_idx[k] = node_idx[2*k+2];
        node_ok[k]  = node_ok[2*k+2];
      end
    end
  end
  assign victim = node_idx[0];

  // Handshake: take an item when the result slot is free or being drained
  assign item_rdy_o = ~res_vld_q | res_pop_i;
  assign fire       = item_vld_i & item_rdy_o;
  assign res_vld_d  = fire | (res_vld_q & ~res_pop_i);

  // Result formation
  always_comb begin
    idx_ext = {2'b00, (found ? sel : victim)};
    res_d.frame_index = idx_ext[1:0];
    if (found) begin
      res_d.outcome      = sel_empty ? nfu_pkg::OUT_PLACED : nfu_pkg::OUT_HIT;
      res_d.evicted_page = '0;
    end else begin
      res_d.outcome      = nfu_pkg::OUT_REPLACE;
      res_d.evicted_page = pg_q[victim];
    end
  end

  // Control: frame valid bits and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
      if (fire && found && sel_empty) begin
        vld_q[sel] <= 1'b1;
      end
    end
  end

  // Frame payload; counts mirror the use count of every resident copy
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
      for (int i = 0; i < FRAMES; i++) begin
        if (match[i]) begin
          cnt_q[i] <= item_cnt_i;
        end
      end
      if (found) begin
        if (sel_empty) begin
          pg_q[sel]  <= item_page_i;
          cnt_q[sel] <= item_cnt_i;
        end
      end else begin
        pg_q[victim]  <= item_page_i;
        cnt_q[victim] <= item_cnt_i;
      end
    end
  end

  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

endmodule

>>> rtl/nfu_page_replacement.sv
// An accepted reference passes the count stage registers, the decoupling queue and the
// result register of the frame stage before its result is on the ports.
// The front stage takes no new reference while the read-modify-write of the last
// one in the single-port use count memory is pending, or while the queue is full.
// Reset: asynchronous, active low; clears frame valid bits, all 256 count valid
// bits at once, the queues and sets frames_in_use to 4. No clearing pass.
module nfu_page_replacement #(
  parameter int FRAMES     = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [nfu_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  logic [nfu_pkg::PageW-1:0]   page_name_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [1:0]                  outcome_o,
  output logic [nfu_pkg::FrameIdW-1:0] frame_index_o,
  output logic [nfu_pkg::PageW-1:0]   evicted_page_o
);

  localparam int QW = nfu_pkg::PageW + COUNT_BITS;

  logic [nfu_pkg::CfgW-1:0]  frames_q;
  logic                      q_full, q_push, q_vld, q_pop;
  logic [nfu_pkg::PageW-1:0] q_page;
  logic [COUNT_BITS-1:0]     q_count;
  logic [QW-1:0]             q_rdata;
  logic                      res_vld;
  nfu_pkg::res_t             res;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= nfu_pkg::FramesReset;
    end else if (cfg_we_i) begin
      frames_q <= cfg_wdata_i;
    end
  end

  // Count stage
  nfu_cnt #(
    .COUNT_BITS (COUNT_BITS)
  ) u_cnt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .page_name_i (page_name_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_page_o    (q_page),
    .q_count_o   (q_count)
  );

  // Decoupling queue
  nfu_fifo #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i ({q_page, q_count}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .vld_o  (q_vld),
    .data_o (q_rdata)
  );

  // Frame stage
  nfu_frames #(
    .FRAMES     (FRAMES),
    .COUNT_BITS (COUNT_BITS)
  ) u_frames (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frames_in_use_i (frames_q),
    .item_vld_i      (q_vld),
    .item_page_i     (q_rdata[QW-1:COUNT_BITS]),
    .item_cnt_i      (q_rdata[COUNT_BITS-1:0]),
    .item_rdy_o      (q_pop),
    .res_vld_o       (res_vld),
    .res_o           (res),
    .res_pop_i       (pop)
  );

  assign empty          = ~res_vld;
  assign outcome_o      = res.outcome;
  assign frame_index_o  = res.frame_index;
  assign evicted_page_o = res.evicted_page;

endmodule

>>> rtl/nfu_checker.sv
// Port-level checks for the page replacement block.
module nfu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [1:0] outcome_o,
  input logic [1:0] frame_index_o,
  input logic [7:0] evicted_page_o
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result shown during reset");

  // Front stage is busy for the cycle after an accepted transaction
  a_busy_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("transaction accepted while count update pending");

  // Evicted page is zero unless a replacement happened
  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && outcome_o != nfu_pkg::OUT_REPLACE) |-> (evicted_page_o == 8'd0))
    else $error("evicted page set without replacement");

  // A waiting result holds until popped
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(outcome_o) && $stable(frame_index_o)
                          && $stable(evicted_page_o)))
    else $error("result changed while stalled");

endmodule

bind nfu_page_replacement nfu_checker u_nfu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .outcome_o      (outcome_o),
  .frame_index_o  (frame_index_o),
  .evicted_page_o (evicted_page_o)
);

>>> test/nfu_page_replacement_checker.sv
`timescale 1ns / 100ps

// Watches the reference and result queues of nfu_page_replacement, predicts
// every result from its own copy of the frame table and use counts, and
// compares each popped result with the oldest prediction.
module nfu_page_replacement_checker #(
  parameter int FRAMES     = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [nfu_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                         push,
  input  logic                         full,
  input  logic [nfu_pkg::PageW-1:0]    page_name_i,
  input  logic                         empty,
  input  logic                         pop,
  input  logic [1:0]                   outcome_o,
  input  logic [nfu_pkg::FrameIdW-1:0] frame_index_o,
  input  logic [nfu_pkg::PageW-1:0]    evicted_page_o,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o
);

  // Shadow of the block's state
  logic [nfu_pkg::PageW-1:0] frame_pg   [FRAMES];
  logic                      frame_vld  [FRAMES];
  logic [COUNT_BITS-1:0]     use_cnt    [256];
  logic [nfu_pkg::CfgW-1:0]  frames_cfg;

  // Predicted results, oldest first
  nfu_pkg::res_t placement_q[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  // Register value clamped to 1..FRAMES
  function automatic int active_frames();
    int n;
    n = int'(frames_cfg);
    if (n < 1) n = 1;
    if (n > FRAMES) n = FRAMES;
    return n;
  endfunction

  // Applies one reference to the shadow state and returns its result
  function automatic nfu_pkg::res_t place_page(input logic [nfu_pkg::PageW-1:0] pg);
    nfu_pkg::res_t r;
    int            n;
    int            victim;
    n = active_frames();
    r.evicted_page = '0;
    // saturating use count
    if (use_cnt[pg] != '1) use_cnt[pg] = use_cnt[pg] + 1'b1;
    // first empty frame or first frame holding the page wins
    for (int i = 0; i < n; i++) begin
      if (!frame_vld[i]) begin
        frame_vld[i]  = 1'b1;
        frame_pg[i]   = pg;
        r.outcome     = nfu_pkg::OUT_PLACED;
        r.frame_index = nfu_pkg::FrameIdW'(i);
        return r;
      end
      if (frame_pg[i] == pg) begin
        r.outcome     = nfu_pkg::OUT_HIT;
        r.frame_index = nfu_pkg::FrameIdW'(i);
        return r;
      end
    end
    // least used resident page, ties to the lowest frame
    victim = 0;
    for (int i = 1; i < n; i++) begin
      if (use_cnt[frame_pg[i]] < use_cnt[frame_pg[victim]]) victim = i;
    end
    r.outcome        = nfu_pkg::OUT_REPLACE;
    r.frame_index    = nfu_pkg::FrameIdW'(victim);
    r.evicted_page   = frame_pg[victim];
    frame_pg[victim] = pg;
    return r;
  endfunction

  // Predict on accepted references, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin : track_proc
    nfu_pkg::res_t want;
    if (!rst_ni) begin
      frames_cfg = nfu_pkg::FramesReset;
      for (int i = 0; i < FRAMES; i++) begin
        frame_vld[i] = 1'b0;
        frame_pg[i]  = '0;
      end
      for (int p = 0; p < 256; p++) use_cnt[p] = '0;
      placement_q.delete();
    end else begin
      if (pop && !empty) begin
        if (placement_q.size() == 0) begin
          $error("result transaction with nothing expected: outcome %0d frame %0d evicted %0d",
                 outcome_o, frame_index_o, evicted_page_o);
          fail_count_o++;
        end else begin
          want = placement_q.pop_front();
          checked_o++;
          if (outcome_o !== want.outcome) begin
            $error("outcome: expected %0d, actual %0d", want.outcome, outcome_o);
            fail_count_o++;
          end
          if (frame_index_o !== want.frame_index) begin
            $error("frame_index: expected %0d, actual %0d", want.frame_index, frame_index_o);
            fail_count_o++;
          end
          if (evicted_page_o !== want.evicted_page) begin
            $error("evicted_page: expected %0d, actual %0d", want.evicted_page,
                   evicted_page_o);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) frames_cfg = cfg_wdata_i;
      if (push && !full) placement_q.push_back(place_page(page_name_i));
    end
    pending_o = placement_q.size();
  end

endmodule

>>> test/nfu_page_replacement_tb.sv
`timescale 1ns / 100ps

module nfu_page_replacement_tb;

  localparam int WatchdogLimit = 2000;
  localparam int TailCycles    = 12;
  localparam int HeavyRefs     = 16;   // repeats of one page to build a large count
  localparam int Chunks        = 9;
  localparam int ChunkRefs     = 46;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b1;
  logic                         cfg_we_i    = 1'b0;
  logic [nfu_pkg::CfgW-1:0]     cfg_wdata_i = '0;
  logic                         push        = 1'b0;
  logic                         full;
  logic [nfu_pkg::PageW-1:0]    page_name_i = '0;
  logic                         empty;
  logic                         pop         = 1'b0;
  logic [1:0]                   outcome_o;
  logic [nfu_pkg::FrameIdW-1:0] frame_index_o;
  logic [nfu_pkg::PageW-1:0]    evicted_page_o;

  int fail_count;
  int pending;
  int checked;
  int sender_gap_pct  = 18;
  int reader_stall_pct = 62;
  int refs_sent       = 0;
  int cfg_writes      = 0;
  int idle_cycles     = 0;

  logic [nfu_pkg::PageW-1:0] hot_pages [8];
  logic [nfu_pkg::CfgW-1:0]  chunk_cfg [Chunks] =
    '{3'd4, 3'd1, 3'd3, 3'd2, 3'd6, 3'd0, 3'd4, 3'd7, 3'd3};

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  nfu_page_replacement i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .page_name_i    (page_name_i),
    .empty          (empty),
    .pop            (pop),
    .outcome_o      (outcome_o),
    .frame_index_o  (frame_index_o),
    .evicted_page_o (evicted_page_o)
  );

  nfu_page_replacement_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .page_name_i    (page_name_i),
    .empty          (empty),
    .pop            (pop),
    .outcome_o      (outcome_o),
    .frame_index_o  (frame_index_o),
    .evicted_page_o (evicted_page_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // Result side: random stalls
  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= reader_stall_pct);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles, %0d results pending",
               idle_cycles, pending);
      $display("nfu_page_replacement_tb: done, errors");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_page(input logic [nfu_pkg::PageW-1:0] pg);
    while ($urandom_range(99) < sender_gap_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push        <= 1'b1;
    page_name_i <= pg;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    refs_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending and wait for every predicted result to be popped
  task automatic drain_results();
    push <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic write_frames(input logic [nfu_pkg::CfgW-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_writes++;
  endtask

  // Mostly a skewed hot set so counts differ, some warm names, some anything
  function automatic logic [nfu_pkg::PageW-1:0] pick_page();
    int r;
    int a;
    int b;
    r = $urandom_range(99);
    a = $urandom_range(7);
    b = $urandom_range(7);
    if (r < 70) return hot_pages[(a < b) ? a : b];
    if (r < 90) return nfu_pkg::PageW'($urandom_range(15) + 8'h40);
    return nfu_pkg::PageW'($urandom_range(255));
  endfunction

  initial begin
    rst_ni <= 1'b0;
    for (int k = 0; k < 8; k++) hot_pages[k] = nfu_pkg::PageW'($urandom_range(255));
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: fill four frames, hits, ties, extremes of the page name
    send_page(8'd0);
    send_page(8'd255);
    send_page(8'd0);
    send_page(8'd7);
    send_page(8'd128);
    send_page(8'd0);
    send_page(8'd200);   // tie among single-use pages goes to frame 1
    send_page(8'd255);
    // two frames: page 7 sits in an inactive frame, so it faults
    write_frames(3'd2);
    send_page(8'd7);
    // zero acts as one frame
    write_frames(3'd0);
    send_page(8'd7);
    // seven acts as four; old contents come back, lowest matching frame wins
    write_frames(3'd7);
    send_page(8'd7);
    send_page(8'd128);
    write_frames(3'd5);
    send_page(8'd1);

    // One frame, one page referenced over and over
    write_frames(3'd1);
    for (int n = 0; n < HeavyRefs; n++) send_page(8'hAA);
    // heavily used page must outlive lightly used ones
    write_frames(3'd2);
    send_page(8'h55);
    send_page(8'h33);
    send_page(8'hAA);

    // Random references in chunks, each with its own frame count
    for (int c = 0; c < Chunks; c++) begin
      case (c / 3)
        0: begin
          sender_gap_pct   = 18;
          reader_stall_pct = 62;
        end
        1: begin
          sender_gap_pct   = 62;
          reader_stall_pct = 18;
        end
        default: begin
          sender_gap_pct   = 0;
          reader_stall_pct = 0;
        end
      endcase
      write_frames(chunk_cfg[c]);
      for (int n = 0; n < ChunkRefs; n++) begin
        if (c == 4 && n == ChunkRefs / 2) drain_results();
        send_page(pick_page());
      end
    end

    drain_results();
    repeat (TailCycles) @(negedge clk_i);
    $display("covered %0d page references, %0d frame-count writes, %0d results checked",
             refs_sent, cfg_writes, checked);
    $display("  incl. hits, placements, replacements with ties and frame counts 0..7");
    if (fail_count == 0) begin
      $display("nfu_page_replacement_tb: done, clean");
    end else begin
      $display("nfu_page_replacement_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/nfu_pkg.sv
rtl/nfu_cnt.sv
rtl/nfu_fifo.sv
rtl/nfu_frames.sv
rtl/nfu_page_replacement.sv
rtl/nfu_checker.sv
test/nfu_page_replacement_checker.sv
test/nfu_page_replacement_tb.sv
